### design/range_score_map_top_tracker_macros.svh
// ----------------------------------------------------------------------------
// Range score map top tracker: assertion macros
// Wrappers for the concurrent checks of the tracker; empty when ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef RANGE_SCORE_MAP_TOP_TRACKER_MACROS_SVH
`define RANGE_SCORE_MAP_TOP_TRACKER_MACROS_SVH

`ifndef ASSERT_OFF
// A property that must hold at every edge outside reset.
`define RSMT_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
// A condition that must never be seen outside reset.
`define RSMT_ASSERT_NEVER(name, clk, rst, cond) \
   name: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");
`else
`define RSMT_ASSERT(name, clk, rst, prop)
`define RSMT_ASSERT_NEVER(name, clk, rst, cond)
`endif

`endif

### design/rsmt_pkg.sv
// ----------------------------------------------------------------------------
// Range score map top tracker: shared package
// Sizes, state codes, memory request type and count field helpers.
// ----------------------------------------------------------------------------
package rsmt_pkg;

   localparam int RANGE_COUNT = 4096;
   localparam int GROUP_SIZE  = 256;
   localparam int RANGE_BITS  = $clog2(RANGE_COUNT);
   localparam int GROUP_BITS  = $clog2(GROUP_SIZE);
   localparam int NGROUPS     = RANGE_COUNT / GROUP_SIZE;
   localparam int GIDX_BITS   = $clog2(NGROUPS);
   localparam int NUM_MEAS    = 3;
   localparam int CNT_W       = 16;
   localparam int SUM_W       = 28;
   localparam int USED_W      = 13;
   localparam int ENTRY_W     = 3 * CNT_W + 1;
   localparam int MARK_BIT    = 3 * CNT_W;
   localparam int REQ_W       = 64;
   localparam int RSP_W       = 200;

   // Measure codes.
   localparam logic [1:0] MEAS_COMPACTION = 2'd0;
   localparam logic [1:0] MEAS_CLEANUP    = 2'd1;
   localparam logic [1:0] MEAS_GARBAGE    = 2'd2;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_LOAD,
      ST_SUM,
      ST_TOP,
      ST_SCAN,
      ST_CHECK,
      ST_UNLINK,
      ST_GLOBAL,
      ST_DONE
   } state_type;

   // One cycle's request to the count memory.
   typedef struct packed {
      logic                  wr_en;
      logic [RANGE_BITS-1:0] wr_addr;
      logic [ENTRY_W-1:0]    wr_data;
      logic [RANGE_BITS-1:0] rd_addr;
   } mem_req_type;

   // Pick the count of one measure out of a stored entry.
   function automatic logic [CNT_W-1:0] entry_count(input logic [ENTRY_W-1:0] e,
                                                    input logic [1:0] m);
      logic [CNT_W-1:0] c;
      case (m)
         MEAS_COMPACTION: c = e[CNT_W-1:0];
         MEAS_CLEANUP:    c = e[2*CNT_W-1:CNT_W];
         default:         c = e[3*CNT_W-1:2*CNT_W];
      endcase
      return c;
   endfunction

endpackage

### design/rsmt_mem.sv
// ----------------------------------------------------------------------------
// Range score map top tracker: count memory
// One entry per range: compacted mark and three 16-bit counts, read registered.
// ----------------------------------------------------------------------------
module rsmt_mem (
   input  logic                              clock,
   input  rsmt_pkg::mem_req_type             req,
   output logic [rsmt_pkg::ENTRY_W-1:0]      rd_data
);
   import rsmt_pkg::*;

   logic [ENTRY_W-1:0] mem [RANGE_COUNT];

   // Single write port and one registered read port.
   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem[req.wr_addr] <= req.wr_data;
      end
      rd_data <= mem[req.rd_addr];
   end

endmodule

### design/range_score_map_top_tracker.sv
// Each update is read, written and summed, then each measure's group top is updated and,
// where the top range falls, rescanned; a group whose tops are all zero is unlinked and
// wiped, and a walk over the groups forms the global tops.
// Throughput: one update at a time; req_tready is low until the sequencer is idle again.
// Reset: synchronous; afterwards a clearing pass walks the count memory, one entry
// a cycle, and req_tready stays low until it ends.
// ----------------------------------------------------------------------------
// Range score map top tracker
// Keeps per-range counts, per-group and global top scores, and running totals.
// ----------------------------------------------------------------------------
`include "range_score_map_top_tracker_macros.svh"

module range_score_map_top_tracker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   // range_id[11:0], blob_count[27:12], deletion_count[43:28],
   // garbage_count[59:44], compacted[60], zero fill
   input  logic [rsmt_pkg::REQ_W-1:0]   req_tdata,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // top_compaction_range[11:0], top_compaction_score[27:12],
   // top_cleanup_range[39:28], top_cleanup_score[55:40],
   // top_garbage_range[67:56], top_garbage_score[83:68], used_ranges[96:84],
   // allocated_ranges[109:97], total_blobs[137:110], total_deletions[165:138],
   // total_garbage[193:166], zero fill
   output logic [rsmt_pkg::RSP_W-1:0]   rsp_tdata
);
   import rsmt_pkg::*;

   localparam logic [GROUP_BITS:0]   SCAN_END   = (GROUP_BITS+1)'(GROUP_SIZE);
   localparam logic [RANGE_BITS-1:0] CLEAR_LAST = RANGE_BITS'(RANGE_COUNT - 1);
   localparam logic [GROUP_BITS-1:0] GROUP_LAST = GROUP_BITS'(GROUP_SIZE - 1);
   localparam logic [GIDX_BITS-1:0]  GIDX_LAST  = GIDX_BITS'(NGROUPS - 1);
   localparam logic [SUM_W-1:0]      SUM_MAX    = {SUM_W{1'b1}};
   localparam logic [USED_W-1:0]     USED_MAX   = {USED_W{1'b1}};

   state_type state_ff, state_in;

   logic [RANGE_BITS-1:0] rid_ff, rid_in;
   logic [ENTRY_W-1:0]    new_ff, new_in;
   logic [ENTRY_W-1:0]    old_ff, old_in;
   logic [1:0]            meas_ff, meas_in;
   logic [SUM_W-1:0]      sum_ff [NUM_MEAS];
   logic [SUM_W-1:0]      sum_in [NUM_MEAS];
   logic [USED_W-1:0]     used_ff, used_in;

   logic [RANGE_BITS-1:0] top_range_ff [NGROUPS][NUM_MEAS];
   logic [RANGE_BITS-1:0] top_range_in [NGROUPS][NUM_MEAS];
   logic [CNT_W-1:0]      top_score_ff [NGROUPS][NUM_MEAS];
   logic [CNT_W-1:0]      top_score_in [NGROUPS][NUM_MEAS];
   logic [NGROUPS-1:0]    linked_ff, linked_in;

   logic [GROUP_BITS:0]   scan_cnt_ff, scan_cnt_in;
   logic                  issue_ff, issue_in;
   logic [GROUP_BITS-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0]      best_ff, best_in;
   logic [GROUP_BITS-1:0] best_idx_ff, best_idx_in;
   logic [CNT_W-1:0]      first_ff, first_in;
   logic [RANGE_BITS-1:0] clr_cnt_ff, clr_cnt_in;

   logic [GIDX_BITS-1:0]  gk_ff, gk_in;
   logic                  found_ff, found_in;
   logic [CNT_W-1:0]      bs_ff, bs_in;
   logic [RANGE_BITS-1:0] br_ff, br_in;
   logic [GIDX_BITS:0]    linked_n_ff, linked_n_in;
   logic [RANGE_BITS-1:0] res_range_ff [NUM_MEAS];
   logic [RANGE_BITS-1:0] res_range_in [NUM_MEAS];
   logic [CNT_W-1:0]      res_score_ff [NUM_MEAS];
   logic [CNT_W-1:0]      res_score_in [NUM_MEAS];

   logic                  rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_W-1:0]      rsp_data_ff, rsp_data_in;

   mem_req_type           mem_req;
   logic [ENTRY_W-1:0]    rd_data;

   // Shared decode of the current step.
   logic [GIDX_BITS-1:0]  grp;
   logic [GIDX_BITS-1:0]  tidx;
   logic [RANGE_BITS-1:0] cur_range;
   logic [CNT_W-1:0]      cur_score;
   logic                  skip_marked;
   logic [CNT_W-1:0]      new_score;
   logic                  top_take;
   logic                  top_rescan;
   logic                  scan_issue;
   logic                  scan_done;
   logic                  all_zero;
   logic                  out_free;
   logic                  req_fire;
   logic                  meas_last;
   logic [CNT_W-1:0]      old_cnt, new_cnt, scan_cnt_val;
   logic [SUM_W-1:0]      sum_diff;
   logic [SUM_W:0]        sum_add;
   logic [SUM_W-1:0]      sum_res;
   logic                  glob_take;

   assign grp         = rid_ff[RANGE_BITS-1:GROUP_BITS];
   assign tidx        = (state_ff == ST_GLOBAL) ? gk_ff : grp;
   assign cur_range   = top_range_ff[tidx][meas_ff];
   assign cur_score   = top_score_ff[tidx][meas_ff];
   assign skip_marked = (meas_ff != MEAS_CLEANUP);
   assign new_cnt     = entry_count(new_ff, meas_ff);
   assign old_cnt     = entry_count(old_ff, meas_ff);
   assign new_score   = (skip_marked && new_ff[MARK_BIT]) ? '0 : new_cnt;
   assign top_take    = cur_score < new_score;
   assign top_rescan  = !top_take && (cur_range == rid_ff);
   assign scan_issue  = scan_cnt_ff < SCAN_END;
   assign scan_done   = (scan_cnt_ff == SCAN_END) && !issue_ff;
   assign all_zero    = (top_score_ff[grp][0] == '0) && (top_score_ff[grp][1] == '0) &&
                        (top_score_ff[grp][2] == '0);
   assign out_free    = !rsp_tvalid_ff || rsp_tready;
   assign req_fire    = req_tvalid && req_tready;
   assign meas_last   = (meas_ff == MEAS_GARBAGE);
   assign scan_cnt_val = entry_count(rd_data, meas_ff);
   assign glob_take   = linked_ff[gk_ff] && (!found_ff || (cur_score > bs_ff));

   // Shared total unit: drop the old count (floor zero), add the new, saturate.
   assign sum_diff = (sum_ff[meas_ff] >= SUM_W'(old_cnt)) ?
                     (sum_ff[meas_ff] - SUM_W'(old_cnt)) : '0;
   assign sum_add  = {1'b0, sum_diff} + (SUM_W+1)'(new_cnt);
   assign sum_res  = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Count memory requests.
   always_comb begin
      mem_req.wr_en   = 1'b0;
      mem_req.wr_addr = rid_ff;
      mem_req.wr_data = '0;
      mem_req.rd_addr = rid_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = clr_cnt_ff;
         end
         ST_LOAD: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_data = new_ff;
         end
         ST_UNLINK: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = {grp, clr_cnt_ff[GROUP_BITS-1:0]};
         end
         ST_SCAN: begin
            if (scan_issue) begin
               mem_req.rd_addr = {grp, scan_cnt_ff[GROUP_BITS-1:0]};
            end
         end
         default: begin
         end
      endcase
   end

   rsmt_mem u_mem (
      .clock   (clock),
      .req     (mem_req),
      .rd_data (rd_data)
   );

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:  if (clr_cnt_ff == CLEAR_LAST) state_in = ST_IDLE;
         ST_IDLE:   if (req_fire) state_in = ST_READ;
         ST_READ:   state_in = ST_LOAD;
         ST_LOAD:   state_in = ST_SUM;
         ST_SUM:    if (meas_last) state_in = ST_TOP;
         ST_TOP: begin
            if (top_rescan) begin
               state_in = ST_SCAN;
            end else if (meas_last) begin
               state_in = ST_CHECK;
            end
         end
         ST_SCAN: begin
            if (scan_done) begin
               state_in = meas_last ? ST_CHECK : ST_TOP;
            end
         end
         ST_CHECK:  state_in = all_zero ? ST_UNLINK : ST_GLOBAL;
         ST_UNLINK: begin
            if (clr_cnt_ff[GROUP_BITS-1:0] == GROUP_LAST) state_in = ST_GLOBAL;
         end
         ST_GLOBAL: if ((gk_ff == GIDX_LAST) && meas_last) state_in = ST_DONE;
         ST_DONE:   if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Datapath next values for each step.
   always_comb begin
      rid_in        = rid_ff;
      new_in        = new_ff;
      old_in        = old_ff;
      meas_in       = meas_ff;
      sum_in        = sum_ff;
      used_in       = used_ff;
      top_range_in  = top_range_ff;
      top_score_in  = top_score_ff;
      linked_in     = linked_ff;
      scan_cnt_in   = scan_cnt_ff;
      issue_in      = 1'b0;
      idx_in        = idx_ff;
      best_in       = best_ff;
      best_idx_in   = best_idx_ff;
      first_in      = first_ff;
      clr_cnt_in    = clr_cnt_ff;
      gk_in         = gk_ff;
      found_in      = found_ff;
      bs_in         = bs_ff;
      br_in         = br_ff;
      linked_n_in   = linked_n_ff;
      res_range_in  = res_range_ff;
      res_score_in  = res_score_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;

      unique case (state_ff)
         ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + 1'b1;
         end
         ST_IDLE: begin
            // Capture the transaction and link its group.
            if (req_fire) begin
               rid_in = req_tdata[RANGE_BITS-1:0];
               new_in = req_tdata[RANGE_BITS+ENTRY_W-1:RANGE_BITS];
               linked_in[req_tdata[RANGE_BITS-1:GROUP_BITS]] = 1'b1;
            end
         end
         ST_READ: begin
         end
         ST_LOAD: begin
            // Old entry is on the read port; the new one is written now.
            old_in  = rd_data;
            meas_in = MEAS_COMPACTION;
            if ((rd_data[MARK_BIT-1:0] == '0) && (new_ff[MARK_BIT-1:0] != '0)) begin
               if (used_ff != USED_MAX) used_in = used_ff + 1'b1;
            end else if ((rd_data[MARK_BIT-1:0] != '0) &&
                         (new_ff[MARK_BIT-1:0] == '0)) begin
               if (used_ff != '0) used_in = used_ff - 1'b1;
            end
         end
         ST_SUM: begin
            sum_in[meas_ff] = sum_res;
            meas_in = meas_last ? MEAS_COMPACTION : meas_ff + 1'b1;
         end
         ST_TOP: begin
            // A higher score takes the group top; a falling top forces a rescan.
            if (top_take) begin
               top_range_in[grp][meas_ff] = rid_ff;
               top_score_in[grp][meas_ff] = new_score;
            end
            if (top_rescan) begin
               scan_cnt_in = '0;
               best_in     = '0;
               best_idx_in = '0;
               first_in    = '0;
            end else if (!meas_last) begin
               meas_in = meas_ff + 1'b1;
            end
         end
         ST_SCAN: begin
            if (scan_issue) begin
               issue_in    = 1'b1;
               idx_in      = scan_cnt_ff[GROUP_BITS-1:0];
               scan_cnt_in = scan_cnt_ff + 1'b1;
            end
            // Returning entry: first strictly greater count wins.
            if (issue_ff) begin
               if (idx_ff == '0) first_in = scan_cnt_val;
               if (!(skip_marked && rd_data[MARK_BIT]) && (scan_cnt_val > best_ff)) begin
                  best_in     = scan_cnt_val;
                  best_idx_in = idx_ff;
               end
            end
            if (scan_done) begin
               top_range_in[grp][meas_ff] = {grp, best_idx_ff};
               top_score_in[grp][meas_ff] = (best_ff != '0) ? best_ff : first_ff;
               if (!meas_last) meas_in = meas_ff + 1'b1;
            end
         end
         ST_CHECK: begin
            // A group with all tops at zero is unlinked and its entries wiped.
            if (all_zero) begin
               linked_in[grp] = 1'b0;
               for (int m = 0; m < NUM_MEAS; m++) begin
                  top_range_in[grp][m] = '0;
                  top_score_in[grp][m] = '0;
               end
            end
            clr_cnt_in  = '0;
            gk_in       = '0;
            found_in    = 1'b0;
            bs_in       = '0;
            br_in       = '0;
            linked_n_in = '0;
            meas_in     = MEAS_COMPACTION;
         end
         ST_UNLINK: begin
            clr_cnt_in = clr_cnt_ff + 1'b1;
         end
         ST_GLOBAL: begin
            // Walk the groups once per measure; ties stay with the lower group.
            if (meas_ff == MEAS_COMPACTION) begin
               linked_n_in = linked_n_ff + (GIDX_BITS+1)'(linked_ff[gk_ff]);
            end
            if (glob_take) begin
               found_in = 1'b1;
               bs_in    = cur_score;
               br_in    = cur_range;
            end
            gk_in = gk_ff + 1'b1;
            if (gk_ff == GIDX_LAST) begin
               res_range_in[meas_ff] = glob_take ? cur_range : br_ff;
               res_score_in[meas_ff] = glob_take ? cur_score : bs_ff;
               found_in = 1'b0;
               bs_in    = '0;
               br_in    = '0;
               if (!meas_last) meas_in = meas_ff + 1'b1;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_data_in = {6'b0, sum_ff[2], sum_ff[1], sum_ff[0],
                              USED_W'({linked_n_ff, {GROUP_BITS{1'b0}}}), used_ff,
                              res_score_ff[2], res_range_ff[2],
                              res_score_ff[1], res_range_ff[1],
                              res_score_ff[0], res_range_ff[0]};
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers with reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_cnt_ff    <= '0;
         sum_ff        <= '{default: '0};
         used_ff       <= '0;
         top_range_ff  <= '{default: '{default: '0}};
         top_score_ff  <= '{default: '{default: '0}};
         linked_ff     <= '0;
         issue_ff      <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_cnt_ff    <= clr_cnt_in;
         sum_ff        <= sum_in;
         used_ff       <= used_in;
         top_range_ff  <= top_range_in;
         top_score_ff  <= top_score_in;
         linked_ff     <= linked_in;
         issue_ff      <= issue_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      rid_ff       <= rid_in;
      new_ff       <= new_in;
      old_ff       <= old_in;
      meas_ff      <= meas_in;
      scan_cnt_ff  <= scan_cnt_in;
      idx_ff       <= idx_in;
      best_ff      <= best_in;
      best_idx_ff  <= best_idx_in;
      first_ff     <= first_in;
      gk_ff        <= gk_in;
      found_ff     <= found_in;
      bs_ff        <= bs_in;
      br_ff        <= br_in;
      linked_n_ff  <= linked_n_in;
      res_range_ff <= res_range_in;
      res_score_ff <= res_score_in;
      rsp_data_ff  <= rsp_data_in;
   end

   // Checks on the sequencer.
   `RSMT_ASSERT(a_accept_reads, clock, reset, req_tvalid && req_tready |=> state_ff == ST_READ)
   `RSMT_ASSERT_NEVER(a_scan_bound, clock, reset, (state_ff == ST_SCAN) && (scan_cnt_ff > SCAN_END))
   `RSMT_ASSERT(a_done_delivers, clock, reset, (state_ff == ST_DONE) && out_free |=> rsp_tvalid)
   `RSMT_ASSERT_NEVER(a_meas_bound, clock, reset, (state_ff == ST_GLOBAL) && (meas_ff > MEAS_GARBAGE))

endmodule

### tb/range_score_map_top_tracker_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Range score map top tracker: result checker
// Watches both streams, keeps its own copy of the range counts and the group
// tops, predicts each result and compares the whole result word with it.
// ----------------------------------------------------------------------------
module range_score_map_top_tracker_checker
   import rsmt_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   input  logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,
   input  logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  logic [RSP_W-1:0] rsp_tdata,
   output int               fail_count,
   output int               pending_count
);

   localparam logic [SUM_W-1:0]  SUM_LIMIT  = '1;
   localparam logic [USED_W-1:0] USED_LIMIT = '1;

   // Model state.
   logic [CNT_W-1:0]      cnt_mem [NUM_MEAS][RANGE_COUNT];
   logic                  mark_mem [RANGE_COUNT];
   logic                  linked [NGROUPS];
   logic [RANGE_BITS-1:0] grp_range [NGROUPS][NUM_MEAS];
   logic [CNT_W-1:0]      grp_score [NGROUPS][NUM_MEAS];
   logic [USED_W-1:0]     used_ranges;
   logic [SUM_W-1:0]      totals [NUM_MEAS];

   logic [RSP_W-1:0] status_queue [$];

   // Clear one group of the model.
   function automatic void clear_group(input int g);
      for (int i = 0; i < GROUP_SIZE; i++) begin
         for (int m = 0; m < NUM_MEAS; m++) cnt_mem[m][g*GROUP_SIZE+i] = '0;
         mark_mem[g*GROUP_SIZE+i] = 1'b0;
      end
      for (int m = 0; m < NUM_MEAS; m++) begin
         grp_range[g][m] = '0;
         grp_score[g][m] = '0;
      end
      linked[g] = 1'b0;
   endfunction

   // Apply one update and return the packed status that follows it.
   function automatic logic [RSP_W-1:0] apply_update(input logic [REQ_W-1:0] d);
      logic [RANGE_BITS-1:0] rid;
      logic [CNT_W-1:0]      nv [NUM_MEAS];
      logic                  comp, was_empty, now_empty, skip, found;
      int                    g, base, bi, linked_n;
      logic [CNT_W-1:0]      s, best;
      logic [SUM_W:0]        t;
      logic [RSP_W-1:0]      r;
      logic [RANGE_BITS-1:0] br;
      logic [CNT_W-1:0]      bs;
      rid   = d[11:0];
      nv[0] = d[27:12];
      nv[1] = d[43:28];
      nv[2] = d[59:44];
      comp  = d[60];
      g     = rid / GROUP_SIZE;
      base  = g * GROUP_SIZE;
      linked[g] = 1'b1;
      for (int m = 0; m < NUM_MEAS; m++) begin
         t = (totals[m] >= cnt_mem[m][rid]) ? totals[m] - cnt_mem[m][rid] : '0;
         t = t + nv[m];
         totals[m] = (t > SUM_LIMIT) ? SUM_LIMIT : t[SUM_W-1:0];
      end
      was_empty = cnt_mem[0][rid] == 0 && cnt_mem[1][rid] == 0 && cnt_mem[2][rid] == 0;
      now_empty = nv[0] == 0 && nv[1] == 0 && nv[2] == 0;
      if (was_empty && !now_empty) begin
         if (used_ranges < USED_LIMIT) used_ranges++;
      end else if (!was_empty && now_empty) begin
         if (used_ranges > 0) used_ranges--;
      end
      mark_mem[rid] = comp;
      for (int m = 0; m < NUM_MEAS; m++) cnt_mem[m][rid] = nv[m];
      // Per-group tops, with a rescan when the top range falls.
      for (int m = 0; m < NUM_MEAS; m++) begin
         skip = (m != MEAS_CLEANUP);
         s = (skip && comp) ? '0 : nv[m];
         if (grp_score[g][m] < s) begin
            grp_range[g][m] = rid;
            grp_score[g][m] = s;
         end else if (grp_range[g][m] == rid) begin
            best = '0;
            bi   = 0;
            for (int i = 0; i < GROUP_SIZE; i++) begin
               if (!(skip && mark_mem[base+i]) && cnt_mem[m][base+i] > best) begin
                  best = cnt_mem[m][base+i];
                  bi   = i;
               end
            end
            grp_range[g][m] = RANGE_BITS'(base + bi);
            grp_score[g][m] = cnt_mem[m][base+bi];
         end
      end
      if (grp_score[g][0] == 0 && grp_score[g][1] == 0 && grp_score[g][2] == 0)
         clear_group(g);
      r = '0;
      for (int m = 0; m < NUM_MEAS; m++) begin
         found = 1'b0;
         br = '0;
         bs = '0;
         for (int k = 0; k < NGROUPS; k++) begin
            if (linked[k] && (!found || grp_score[k][m] > bs)) begin
               found = 1'b1;
               bs = grp_score[k][m];
               br = grp_range[k][m];
            end
         end
         r[28*m +: 12]      = br;
         r[28*m + 12 +: 16] = bs;
      end
      linked_n = 0;
      for (int k = 0; k < NGROUPS; k++) linked_n += linked[k];
      r[96:84]   = used_ranges;
      r[109:97]  = USED_W'(linked_n * GROUP_SIZE);
      r[137:110] = totals[0];
      r[165:138] = totals[1];
      r[193:166] = totals[2];
      return r;
   endfunction

   assign pending_count = status_queue.size();

   // Predict on each input transaction, compare on each result transaction.
   always @(posedge clock) begin
      logic [RSP_W-1:0] want;
      if (reset) begin
         for (int g = 0; g < NGROUPS; g++) clear_group(g);
         used_ranges = '0;
         for (int m = 0; m < NUM_MEAS; m++) totals[m] = '0;
         status_queue.delete();
         fail_count = 0;
      end else begin
         if (req_tvalid && req_tready)
            status_queue.insert(status_queue.size(), apply_update(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (status_queue.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) $display("unexpected result %h", rsp_tdata);
            end else begin
               want = status_queue.pop_front();
               if (want != rsp_tdata) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("result mismatch: expected %h actual %h", want, rsp_tdata);
               end
            end
         end
      end
   end

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Range score map top tracker: testbench top
// Drives directed and random range updates with random gaps and stalls and
// reports the verdict from the checker's failure and pending counts.
// ----------------------------------------------------------------------------
module testbench;
   import rsmt_pkg::*;

   localparam int WATCHDOG_LIMIT = 40000;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   int               fail_count;
   int               pending_count;
   int               idle_cycles = 0;
   bit               calm = 1'b0;
   bit               hold_off = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   range_score_map_top_tracker dut (.*);

   range_score_map_top_tracker_checker checker_inst (.*);

   // Receiver: random stalls, none while calm, stalled throughout while held off.
   always @(negedge clock) begin
      if (hold_off) rsp_tready <= 1'b0;
      else rsp_tready <= calm || ($urandom_range(99) >= 26);
   end

   // Watchdog on cycles without any transaction.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (!reset && idle_cycles >= WATCHDOG_LIMIT) begin
         $display("range_score_map_top_tracker verification failed");
         $finish;
      end
   end

   // Offer one update and wait for its transaction; the valid stays up into
   // the next update unless a random gap drops it.
   task automatic send_update(input logic [11:0] rid, input logic [15:0] b,
                              input logic [15:0] del, input logic [15:0] gar,
                              input logic comp);
      while (!calm && $urandom_range(99) < 26) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tdata  <= {3'b000, comp, gar, del, b, rid};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [15:0] rand_count();
      case ($urandom_range(5))
         0: return 16'd0;
         1: return 16'hFFFF;
         2: return 16'($urandom_range(3));
         default: return 16'($urandom());
      endcase
   endfunction

   // Hold the receiver off for a long stretch.
   initial begin
      @(negedge reset);
      repeat (6000) @(posedge clock);
      hold_off = 1'b1;
      repeat (3000) @(posedge clock);
      hold_off = 1'b0;
   end

   initial begin
      logic [11:0] rid;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // Directed: extremes, compacted flag, top falling, unlink, tie.
      send_update(12'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
      send_update(12'd4095, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
      send_update(12'd5, 16'd10, 16'd20, 16'd30, 1'b1);
      send_update(12'd0, 16'd1, 16'd2, 16'd3, 1'b0);
      send_update(12'd0, 16'd0, 16'd0, 16'd0, 1'b0);
      send_update(12'd5, 16'd0, 16'd0, 16'd0, 1'b0);
      send_update(12'd300, 16'd7, 16'd0, 16'd0, 1'b0);
      send_update(12'd301, 16'd7, 16'd0, 16'd0, 1'b0);
      send_update(12'd300, 16'd2, 16'd0, 16'd0, 1'b0);
      send_update(12'd301, 16'd9, 16'd9, 16'd9, 1'b1);
      send_update(12'd301, 16'd0, 16'd0, 16'd0, 1'b0);
      send_update(12'd300, 16'd0, 16'd0, 16'd0, 1'b0);
      send_update(12'd4095, 16'd0, 16'd0, 16'd0, 1'b0);
      send_update(12'hAAA, 16'h5555, 16'hAAAA, 16'h5555, 1'b1);
      send_update(12'h555, 16'hAAAA, 16'h5555, 16'hAAAA, 1'b0);
      // Random: few hot ranges per group so tops fall and rescans happen.
      for (int n = 0; n < 1600; n++) begin
         calm = (n >= 800 && n < 1000);
         if ($urandom_range(9) < 7)
            rid = {4'($urandom_range(3)), 8'($urandom_range(7))};
         else rid = 12'($urandom());
         if ($urandom_range(7) == 0)
            send_update(rid, 16'd0, 16'd0, 16'd0, 1'($urandom()));
         else send_update(rid, rand_count(), rand_count(), rand_count(), 1'($urandom()));
      end
      req_tvalid <= 1'b0;
      calm = 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("range_score_map_top_tracker verification clean");
      else
         $display("range_score_map_top_tracker verification failed");
      $finish;
   end

endmodule
